/* rtl/core/pmr_pkg.sv */
// shared types and constants of the pair magnetic rotation pipeline
package pmr_pkg;

  // word and fixed-point formats
  localparam int WORD_W = 32;
  localparam int FRAC_V = 30;
  localparam int FRAC_F = 16;

  // configuration register indexes
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_FULL_STEP_MODE = 1'd0;
  localparam logic [IDX_W-1:0] REG_STEP_SQUARED   = 1'd1;

  localparam logic [31:0] STEP_SQUARED_RST = 32'd65536;
  localparam logic [63:0] THETA2_MAX = 64'd4294967292;
  localparam logic signed [32:0] ONE_V = 33'sd1073741824;

  // payload riding along the norm square root
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        einv;
    logic               sgn_x;
    logic               sgn_y;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
  } norm_side_t;

  // payload riding along the direction divider
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        einv;
    logic               sgn_x;
    logic               sgn_y;
  } div_side_t;

  // velocity and field direction
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } vel_dir_t;

  // payload riding along the angle square root
  typedef struct packed {
    vel_dir_t           vd;
    logic signed [33:0] vb;
    logic signed [33:0] vdu;
    logic [31:0]        t2;
  } rot_side_t;

endpackage

/* rtl/core/pmr_sqrt_pipe.sv */
// pipelined integer square root, one result bit per stage, with floor root and remainder flag
module pmr_sqrt_pipe #(
  parameter int RW = 32,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [2*RW-1:0] x_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic            rem_nz_o,
  output logic [SW-1:0]   side_o
);
  localparam int XW = 2 * RW;

  logic [RW+1:0] rem_w  [RW+1];
  logic [RW-1:0] root_w [RW+1];
  logic [XW-1:0] x_w    [RW+1];
  logic [SW-1:0] side_w [RW+1];
  logic [RW:0]   vld_w;

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign x_w[0]    = x_i;
  assign side_w[0] = side_i;
  assign vld_w[0]  = vld_i;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;
    logic [RW+1:0] rem_d;
    logic [RW+1:0] rem_q;
    logic [RW-1:0] root_q;
    logic [XW-1:0] x_q;
    logic [SW-1:0] side_q;
    logic          vld_q;

    // bring down the next bit pair and try the new root bit
    assign rem_sh = {rem_w[s][RW-1:0], x_w[s][XW-1 -: 2]};
    assign trial  = {root_w[s], 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= {root_w[s][RW-2:0], ge};
        x_q    <= x_w[s] << 2;
        side_q <= side_w[s];
      end
    end

    assign rem_w[s+1]  = rem_q;
    assign root_w[s+1] = root_q;
    assign x_w[s+1]    = x_q;
    assign side_w[s+1] = side_q;
    assign vld_w[s+1]  = vld_q;
  end

  assign vld_o    = vld_w[RW];
  assign root_o   = root_w[RW];
  assign rem_nz_o = |rem_w[RW];
  assign side_o   = side_w[RW];

endmodule

/* rtl/core/pmr_div_pipe.sv */
// pipelined two-lane restoring divider: floor(num * 2^(QW-1) / den) for num <= den
module pmr_div_pipe #(
  parameter int QW = 31,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] num_a_i,
  input  logic [DW-1:0] num_b_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_a_o,
  output logic [QW-1:0] quo_b_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);
  logic [DW-1:0] rem_w  [2][QW+1];
  logic [QW-1:0] strm_w [2][QW+1];
  logic [QW-1:0] quo_w  [2][QW+1];
  logic [DW-1:0] den_w  [QW+1];
  logic [SW-1:0] side_w [QW+1];
  logic [QW:0]   vld_w;

  // top part of the scaled numerator starts the remainder, its low bit is streamed in
  assign rem_w[0][0]  = num_a_i >> 1;
  assign rem_w[1][0]  = num_b_i >> 1;
  assign strm_w[0][0] = {num_a_i[0], {(QW-1){1'b0}}};
  assign strm_w[1][0] = {num_b_i[0], {(QW-1){1'b0}}};
  assign quo_w[0][0]  = '0;
  assign quo_w[1][0]  = '0;
  assign den_w[0]     = den_i;
  assign side_w[0]    = side_i;
  assign vld_w[0]     = vld_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] den_q;
    logic [SW-1:0] side_q;
    logic          vld_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q  <= den_w[s];
        side_q <= side_w[s];
      end
    end

    assign den_w[s+1]  = den_q;
    assign side_w[s+1] = side_q;
    assign vld_w[s+1]  = vld_q;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0]   rem_sh;
      logic          ge;
      logic [DW:0]   rem_sub;
      logic [DW-1:0] rem_d;
      logic [DW-1:0] rem_q;
      logic [QW-1:0] strm_q;
      logic [QW-1:0] quo_q;

      // shift in one numerator bit and subtract when it fits
      assign rem_sh  = {rem_w[l][s], strm_w[l][s][QW-1]};
      assign ge      = (rem_sh >= {1'b0, den_w[s]});
      assign rem_sub = rem_sh - {1'b0, den_w[s]};
      assign rem_d   = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q  <= rem_d;
          strm_q <= strm_w[l][s] << 1;
          quo_q  <= {quo_w[l][s][QW-2:0], ge};
        end
      end

      assign rem_w[l][s+1]  = rem_q;
      assign strm_w[l][s+1] = strm_q;
      assign quo_w[l][s+1]  = quo_q;
    end
  end

  assign vld_o   = vld_w[QW];
  assign quo_a_o = quo_w[0][QW];
  assign quo_b_o = quo_w[1][QW];
  assign den_o   = den_w[QW];
  assign side_o  = side_w[QW];

endmodule

/* rtl/core/pair_magnetic_rotation.sv */
// Magnetic rotation of one pair particle per beat: a fully pipelined datapath that takes a
// new particle every cycle unless stalled and returns its rotated velocity and rotation
// angle after three input stages, a 32-stage norm square root, a norm rounding stage, a
// 31-stage divider for the field direction, seven multiply stages for the angle squared, a
// 31-stage angle square root, two rotation stages and the output register. When the output
// is stalled the pipeline keeps moving until its last stage holds a particle, so input
// beats are taken while a result waits. Configuration is read directly by the stages, so
// write it only while the pipeline is empty.
module pair_magnetic_rotation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pmr_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pmr_pkg::WORD_W-1:0]  vel_x_i,
  input  logic signed [pmr_pkg::WORD_W-1:0]  vel_y_i,
  input  logic signed [pmr_pkg::WORD_W-1:0]  vel_z_i,
  input  logic [pmr_pkg::WORD_W-1:0]         inv_energy_i,
  input  logic                               negative_charge_i,
  input  logic signed [pmr_pkg::WORD_W-1:0]  field_x_i,
  input  logic signed [pmr_pkg::WORD_W-1:0]  field_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pmr_pkg::WORD_W-1:0]  new_vel_x_o,
  output logic signed [pmr_pkg::WORD_W-1:0]  new_vel_y_o,
  output logic signed [pmr_pkg::WORD_W-1:0]  new_vel_z_o,
  output logic [pmr_pkg::WORD_W-2:0]         rotation_angle_o
);
  import pmr_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic adv;
  logic out_ready;
  logic full_q;
  logic [31:0] step_q;

  // stage a: field magnitudes and signs
  norm_side_t a_side_d, a_side_q;
  logic a_vld_q;
  // stage b: squares
  norm_side_t b_side_q;
  logic b_vld_q;
  logic [63:0] b_sqx_q, b_sqy_q;
  // stage c: squared norm
  norm_side_t c_side_q;
  logic c_vld_q;
  logic [63:0] c_s2_q;
  // norm root
  logic n_vld, n_rem_nz;
  logic [31:0] n_root;
  logic [$bits(norm_side_t)-1:0] n_side_raw;
  norm_side_t n_side;
  // stage d: ceiling norm
  div_side_t d_side_q;
  logic d_vld_q;
  logic [31:0] d_bn_q, d_magx_q, d_magy_q;
  // divider
  logic q_vld;
  logic [30:0] q_x, q_y;
  logic [31:0] q_bn;
  logic [$bits(div_side_t)-1:0] q_side_raw;
  div_side_t q_side;
  // stage e: direction, field times inverse energy
  logic e_vld_q;
  vel_dir_t e_vd_d, e_vd_q;
  logic [63:0] e_gf_q;
  // stage f: cross products and partial squares
  logic f_vld_q;
  vel_dir_t f_vd_q;
  logic [47:0] g_w;
  logic signed [63:0] f_pxuy_q, f_pyux_q, f_pxux_q, f_pyuy_q;
  logic [63:0] f_vz2_q;
  logic [47:0] f_ghh_q, f_ghl_q, f_gll_q;
  // stage g
  logic g_vld_q;
  vel_dir_t g_vd_q;
  logic signed [63:0] cross_w, dot_w;
  logic [95:0] g2full_w;
  logic signed [33:0] g_vb_q, g_vdu_q;
  logic [63:0] g_vz2_q, g_g2_q;
  // stage h
  logic h_vld_q;
  vel_dir_t h_vd_q;
  logic signed [67:0] vb2_w;
  logic signed [33:0] h_vb_q, h_vdu_q;
  logic [63:0] h_vz2_q, h_vb2_q, h_klo_q, h_khi_q;
  // stage i
  logic i_vld_q;
  vel_dir_t i_vd_q;
  logic [63:0] psum_w;
  logic [95:0] kfull_w;
  logic signed [33:0] i_vb_q, i_vdu_q;
  logic [33:0] i_p_q;
  logic [63:0] i_k_q;
  // stage j
  logic j_vld_q;
  vel_dir_t j_vd_q;
  logic signed [33:0] j_vb_q, j_vdu_q;
  logic [65:0] j_tlo_q, j_thi_q;
  // stage k: angle squared
  logic k_vld_q;
  rot_side_t k_side_q;
  logic [97:0] t2full_w;
  logic [63:0] t2sat_w, t2sh_w;
  logic [31:0] t2_w;
  // angle root
  logic r_vld;
  logic [30:0] r_th;
  logic [$bits(rot_side_t)-1:0] r_side_raw;
  rot_side_t r_side;
  // stage l: rotation coefficients
  logic l_vld_q;
  vel_dir_t l_vd_q;
  logic [30:0] a3h_w;
  logic signed [33:0] l_vb_q;
  logic [30:0] l_th_q;
  logic signed [32:0] l_a1_q;
  logic signed [63:0] l_a2p_q;
  logic signed [65:0] l_a3p_q;
  // stage m: rotation products
  logic m_vld_q;
  logic signed [33:0] a2_w;
  logic signed [35:0] a3_w;
  logic [30:0] m_th_q;
  logic signed [64:0] m_xa1_q, m_ya1_q, m_za1_q;
  logic signed [65:0] m_a2uy_q, m_a2ux_q, m_thvb_q;
  logic signed [67:0] m_a3ux_q, m_a3uy_q;
  // output
  logic signed [39:0] nx_w, ny_w, nz_w;
  logic out_valid_q;
  logic signed [31:0] nvx_q, nvy_q, nvz_q;
  logic [30:0] ang_q;

  // pipeline advances unless a finished beat sits in the last stage behind a stalled output
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = out_ready || !m_vld_q;
  assign in_stall_o = !adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      step_q <= STEP_SQUARED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FULL_STEP_MODE: full_q <= cfg_data_i[0];
        REG_STEP_SQUARED:   step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // field after charge sign, split into magnitude and sign
  always_comb begin
    a_side_d.vx    = vel_x_i;
    a_side_d.vy    = vel_y_i;
    a_side_d.vz    = vel_z_i;
    a_side_d.einv  = inv_energy_i;
    a_side_d.sgn_x = negative_charge_i ? (field_x_i != '0 && !field_x_i[31]) : field_x_i[31];
    a_side_d.sgn_y = negative_charge_i ? (field_y_i != '0 && !field_y_i[31]) : field_y_i[31];
    a_side_d.mag_x = field_x_i[31] ? 32'(-field_x_i) : 32'(field_x_i);
    a_side_d.mag_y = field_y_i[31] ? 32'(-field_y_i) : 32'(field_y_i);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
      j_vld_q <= 1'b0;
      k_vld_q <= 1'b0;
      l_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= n_vld;
      e_vld_q <= q_vld;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
      j_vld_q <= i_vld_q;
      k_vld_q <= j_vld_q;
      l_vld_q <= r_vld;
      m_vld_q <= l_vld_q;
    end
  end

  // stages a to c: squared field norm
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q <= a_side_d;
      b_side_q <= a_side_q;
      b_sqx_q  <= a_side_q.mag_x * a_side_q.mag_x;
      b_sqy_q  <= a_side_q.mag_y * a_side_q.mag_y;
      c_side_q <= b_side_q;
      c_s2_q   <= b_sqx_q + b_sqy_q;
    end
  end

  pmr_sqrt_pipe #(
    .RW(32),
    .SW($bits(norm_side_t))
  ) u_norm_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (c_vld_q),
    .x_i      (c_s2_q),
    .side_i   (c_side_q),
    .vld_o    (n_vld),
    .root_o   (n_root),
    .rem_nz_o (n_rem_nz),
    .side_o   (n_side_raw)
  );
  assign n_side = n_side_raw;

  // stage d: round the norm up
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_bn_q         <= n_root + 32'(n_rem_nz);
      d_magx_q       <= n_side.mag_x;
      d_magy_q       <= n_side.mag_y;
      d_side_q.vx    <= n_side.vx;
      d_side_q.vy    <= n_side.vy;
      d_side_q.vz    <= n_side.vz;
      d_side_q.einv  <= n_side.einv;
      d_side_q.sgn_x <= n_side.sgn_x;
      d_side_q.sgn_y <= n_side.sgn_y;
    end
  end

  pmr_div_pipe #(
    .QW(31),
    .DW(32),
    .SW($bits(div_side_t))
  ) u_dir_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (d_vld_q),
    .num_a_i (d_magx_q),
    .num_b_i (d_magy_q),
    .den_i   (d_bn_q),
    .side_i  (d_side_q),
    .vld_o   (q_vld),
    .quo_a_o (q_x),
    .quo_b_o (q_y),
    .den_o   (q_bn),
    .side_o  (q_side_raw)
  );
  assign q_side = q_side_raw;

  // signed unit direction, zero for a zero field
  always_comb begin
    e_vd_d.vx = q_side.vx;
    e_vd_d.vy = q_side.vy;
    e_vd_d.vz = q_side.vz;
    if (q_bn == '0) begin
      e_vd_d.ux = '0;
      e_vd_d.uy = '0;
    end else begin
      e_vd_d.ux = q_side.sgn_x ? (32'sd0 - $signed({1'b0, q_x})) : $signed({1'b0, q_x});
      e_vd_d.uy = q_side.sgn_y ? (32'sd0 - $signed({1'b0, q_y})) : $signed({1'b0, q_y});
    end
  end

  assign g_w = e_gf_q[63:16];

  // stages e and f: direction, energy product, cross products, partial squares of g
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_vd_q   <= e_vd_d;
      e_gf_q   <= q_bn * q_side.einv;
      f_vd_q   <= e_vd_q;
      f_pxuy_q <= $signed(e_vd_q.vx) * $signed(e_vd_q.uy);
      f_pyux_q <= $signed(e_vd_q.vy) * $signed(e_vd_q.ux);
      f_pxux_q <= $signed(e_vd_q.vx) * $signed(e_vd_q.ux);
      f_pyuy_q <= $signed(e_vd_q.vy) * $signed(e_vd_q.uy);
      f_vz2_q  <= $signed(e_vd_q.vz) * $signed(e_vd_q.vz);
      f_ghh_q  <= g_w[47:24] * g_w[47:24];
      f_ghl_q  <= g_w[47:24] * g_w[23:0];
      f_gll_q  <= g_w[23:0] * g_w[23:0];
    end
  end

  // stage g: cross term, dot term, saturated g squared
  assign cross_w  = f_pxuy_q - f_pyux_q;
  assign dot_w    = f_pxux_q + f_pyuy_q;
  assign g2full_w = {f_ghh_q, 48'd0} + {23'd0, f_ghl_q, 25'd0} + 96'(f_gll_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_vd_q  <= f_vd_q;
      g_vb_q  <= cross_w[63:30];
      g_vdu_q <= dot_w[63:30];
      g_vz2_q <= f_vz2_q;
      g_g2_q  <= (|g2full_w[95:80]) ? '1 : g2full_w[79:16];
    end
  end

  // stage h: cross term squared, step product halves
  assign vb2_w = g_vb_q * g_vb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_vd_q  <= g_vd_q;
      h_vb_q  <= g_vb_q;
      h_vdu_q <= g_vdu_q;
      h_vz2_q <= g_vz2_q;
      h_vb2_q <= vb2_w[63:0];
      h_klo_q <= g_g2_q[31:0] * step_q;
      h_khi_q <= g_g2_q[63:32] * step_q;
    end
  end

  // stage i: direction factor and saturated k
  assign psum_w  = h_vz2_q + h_vb2_q;
  assign kfull_w = {h_khi_q, 32'd0} + 96'(h_klo_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_vd_q  <= h_vd_q;
      i_vb_q  <= h_vb_q;
      i_vdu_q <= h_vdu_q;
      i_p_q   <= psum_w[63:30];
      i_k_q   <= (|kfull_w[95:80]) ? '1 : kfull_w[79:16];
    end
  end

  // stage j: angle squared product halves
  always_ff @(posedge clk_i) begin
    if (adv) begin
      j_vd_q  <= i_vd_q;
      j_vb_q  <= i_vb_q;
      j_vdu_q <= i_vdu_q;
      j_tlo_q <= i_p_q * i_k_q[31:0];
      j_thi_q <= i_p_q * i_k_q[63:32];
    end
  end

  // stage k: saturate, apply quarter factor unless in full step mode, clamp
  assign t2full_w = {j_thi_q, 32'd0} + 98'(j_tlo_q);
  assign t2sat_w  = (|t2full_w[97:80]) ? '1 : t2full_w[79:16];
  assign t2sh_w   = full_q ? t2sat_w : (t2sat_w >> 2);
  assign t2_w     = (t2sh_w > THETA2_MAX) ? THETA2_MAX[31:0] : t2sh_w[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_side_q.vd  <= j_vd_q;
      k_side_q.vb  <= j_vb_q;
      k_side_q.vdu <= j_vdu_q;
      k_side_q.t2  <= t2_w;
    end
  end

  pmr_sqrt_pipe #(
    .RW(31),
    .SW($bits(rot_side_t))
  ) u_angle_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (k_vld_q),
    .x_i      ({k_side_q.t2, 30'd0}),
    .side_i   (k_side_q),
    .vld_o    (r_vld),
    .root_o   (r_th),
    .rem_nz_o (),
    .side_o   (r_side_raw)
  );
  assign r_side = r_side_raw;

  // stage l: rotation coefficients
  assign a3h_w = r_side.t2[31:1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_vd_q  <= r_side.vd;
      l_vb_q  <= r_side.vb;
      l_th_q  <= r_th;
      l_a1_q  <= ONE_V - $signed({2'b00, a3h_w});
      l_a2p_q <= $signed({1'b0, r_th}) * $signed(r_side.vd.vz);
      l_a3p_q <= $signed({1'b0, a3h_w}) * $signed(r_side.vdu);
    end
  end

  // stage m: rotation products
  assign a2_w = l_a2p_q[63:30];
  assign a3_w = l_a3p_q[65:30];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_th_q   <= l_th_q;
      m_xa1_q  <= $signed(l_vd_q.vx) * l_a1_q;
      m_ya1_q  <= $signed(l_vd_q.vy) * l_a1_q;
      m_za1_q  <= $signed(l_vd_q.vz) * l_a1_q;
      m_a2uy_q <= a2_w * $signed(l_vd_q.uy);
      m_a2ux_q <= a2_w * $signed(l_vd_q.ux);
      m_a3ux_q <= a3_w * $signed(l_vd_q.ux);
      m_a3uy_q <= a3_w * $signed(l_vd_q.uy);
      m_thvb_q <= $signed({1'b0, l_th_q}) * l_vb_q;
    end
  end

  // new velocity, each product floored before the sum
  assign nx_w = 40'($signed(m_xa1_q[64:30])) - 40'($signed(m_a2uy_q[65:30]))
              + 40'($signed(m_a3ux_q[67:30]));
  assign ny_w = 40'($signed(m_ya1_q[64:30])) + 40'($signed(m_a2ux_q[65:30]))
              + 40'($signed(m_a3uy_q[67:30]));
  assign nz_w = 40'($signed(m_za1_q[64:30])) + 40'($signed(m_thvb_q[65:30]));

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && m_vld_q) begin
      nvx_q <= sat32(nx_w);
      nvy_q <= sat32(ny_w);
      nvz_q <= sat32(nz_w);
      ang_q <= m_th_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_vel_x_o      = nvx_q;
  assign new_vel_y_o      = nvy_q;
  assign new_vel_z_o      = nvz_q;
  assign rotation_angle_o = ang_q;

endmodule
